[sv/psawt_pkg.sv]
// ----------------------------------------------------------------------------
// psawt_pkg
// Shared types, constants and helpers of the sequence/ack window tracker.
// ----------------------------------------------------------------------------
package psawt_pkg;

    localparam int SEQ_W         = 16;
    localparam int WIN_BITS      = 32;
    localparam int WIN_AW        = $clog2(WIN_BITS);
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int IDX_W         = $clog2(WIN_BITS + 2);

    typedef logic [SEQ_W-1:0]    t_seq;
    typedef logic [WIN_BITS-1:0] t_win;
    typedef logic [HIST_AW-1:0]  t_slot;
    typedef logic [IDX_W-1:0]    t_idx;

    typedef enum logic {
        CMD_RX    = 1'b0,
        CMD_BUILD = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_QUIET  = 2'd1,
        KIND_ACKED  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic have_received;
        t_seq latest;
        t_win window;
    } t_rx_state;

    function automatic t_slot slot_of(input t_seq s);
        slot_of = HIST_AW'(s % HISTORY_DEPTH);
    endfunction

endpackage

[sv/packet_seq_ack_window_tracker_core.sv]
// ----------------------------------------------------------------------------
// packet_seq_ack_window_tracker_core
// Build command: one result on the cycle after the transfer, busy stays low.
// Received header: busy until the final result; the candidate subtractor and the single
// history read port check one slot per cycle (33 slots, plus pipeline/flush).
// Acked results stream during the scan; the final one is strobed on the first
// cycle with busy low. Synchronous active-low reset clears counters, window
// and used bits; the history store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module packet_seq_ack_window_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_rx_seq,
    input  logic [15:0] i_rx_ack,
    input  logic [31:0] i_rx_ack_bits,
    input  logic        i_has_messages,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_tx_seq,
    output logic [15:0] o_tx_ack,
    output logic [31:0] o_tx_ack_bits,
    output logic [15:0] o_acked_seq,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    psawt_pkg::t_idx          r_idx, n_idx;
    psawt_pkg::t_seq          r_ack, n_ack;
    psawt_pkg::t_win          r_bits, n_bits;
    logic                     r_p_v, n_p_v;
    psawt_pkg::t_seq          r_p_seq, n_p_seq;
    psawt_pkg::t_slot         r_p_slot, n_p_slot;
    logic                     r_pend_v, n_pend_v;
    psawt_pkg::t_seq          r_pend_seq, n_pend_seq;
    psawt_pkg::t_seq          r_send_seq, n_send_seq;
    psawt_pkg::t_rx_state     r_rx, n_rx;
    logic                     r_ack_owed, n_ack_owed;
    logic [psawt_pkg::HISTORY_DEPTH-1:0] r_used, n_used;

    logic                     r_out_v, n_out_v;
    psawt_pkg::t_kind         r_kind, n_kind;
    psawt_pkg::t_seq          r_tx_seq, n_tx_seq;
    psawt_pkg::t_seq          r_tx_ack, n_tx_ack;
    psawt_pkg::t_win          r_tx_bits, n_tx_bits;
    psawt_pkg::t_seq          r_acked, n_acked;
    logic                     r_last, n_last;

    psawt_pkg::t_rx_state     win_nxt;
    psawt_pkg::t_seq          cand;
    psawt_pkg::t_idx          idx_m1;
    psawt_pkg::t_seq          rd_data;
    logic                     wr_en;
    logic                     rd_en;
    logic                     quiet;
    logic                     hit;

    psawt_win_upd u_win_upd (
        .i_cur    (r_rx),
        .i_rx_seq (i_rx_seq),
        .o_nxt    (win_nxt)
    );

    psawt_hist_ram u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (psawt_pkg::slot_of(r_send_seq)),
        .i_wr_data (r_send_seq),
        .i_rd_en   (rd_en),
        .i_rd_addr (psawt_pkg::slot_of(cand)),
        .o_rd_data (rd_data)
    );

    assign busy   = (r_state != S_IDLE);
    assign cand   = r_ack - psawt_pkg::SEQ_W'(r_idx);
    assign idx_m1 = r_idx - psawt_pkg::IDX_W'(1);
    assign quiet  = !i_has_messages && !r_ack_owed;
    assign hit    = r_p_v && r_used[r_p_slot] && (rd_data == r_p_seq);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_ack      = r_ack;
        n_bits     = r_bits;
        n_p_v      = r_p_v;
        n_p_seq    = r_p_seq;
        n_p_slot   = r_p_slot;
        n_pend_v   = r_pend_v;
        n_pend_seq = r_pend_seq;
        n_send_seq = r_send_seq;
        n_rx       = r_rx;
        n_ack_owed = r_ack_owed;
        n_used     = r_used;
        n_out_v    = 1'b0;
        n_kind     = r_kind;
        n_tx_seq   = r_tx_seq;
        n_tx_ack   = r_tx_ack;
        n_tx_bits  = r_tx_bits;
        n_acked    = r_acked;
        n_last     = r_last;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == psawt_pkg::CMD_RX) begin
                        n_rx       = win_nxt;
                        n_ack_owed = 1'b1;
                        n_ack      = i_rx_ack;
                        n_bits     = i_rx_ack_bits;
                        n_idx      = '0;
                        n_p_v      = 1'b0;
                        n_pend_v   = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        wr_en   = 1'b1;
                        n_used[psawt_pkg::slot_of(r_send_seq)] = !quiet;
                        n_out_v   = 1'b1;
                        n_last    = 1'b1;
                        n_acked   = '0;
                        if (quiet) begin
                            n_kind    = psawt_pkg::KIND_QUIET;
                            n_tx_seq  = '0;
                            n_tx_ack  = '0;
                            n_tx_bits = '0;
                        end else begin
                            n_kind     = psawt_pkg::KIND_HEADER;
                            n_tx_seq   = r_send_seq;
                            n_tx_ack   = r_rx.latest;
                            n_tx_bits  = r_rx.have_received ? (r_rx.window >> 1) : '0;
                            n_send_seq = r_send_seq + psawt_pkg::SEQ_W'(1);
                            n_ack_owed = 1'b0;
                        end
                    end
                end
            end
            S_SCAN: begin
                rd_en    = (r_idx <= psawt_pkg::IDX_W'(psawt_pkg::WIN_BITS));
                n_p_v    = rd_en && ((r_idx == '0)
                           || r_bits[idx_m1[psawt_pkg::WIN_AW-1:0]]);
                n_p_seq  = cand;
                n_p_slot = psawt_pkg::slot_of(cand);
                n_idx    = r_idx + psawt_pkg::IDX_W'(1);
                if (hit) begin
                    n_used[r_p_slot] = 1'b0;
                    if (r_pend_v) begin
                        n_out_v   = 1'b1;
                        n_kind    = psawt_pkg::KIND_ACKED;
                        n_tx_seq  = '0;
                        n_tx_ack  = '0;
                        n_tx_bits = '0;
                        n_acked   = r_pend_seq;
                        n_last    = 1'b0;
                    end
                    n_pend_seq = r_p_seq;
                    n_pend_v   = 1'b1;
                end
                if (r_idx == psawt_pkg::IDX_W'(psawt_pkg::WIN_BITS + 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_out_v   = 1'b1;
                n_tx_seq  = '0;
                n_tx_ack  = '0;
                n_tx_bits = '0;
                n_last    = 1'b1;
                if (r_pend_v) begin
                    n_kind  = psawt_pkg::KIND_ACKED;
                    n_acked = r_pend_seq;
                end else begin
                    n_kind  = psawt_pkg::KIND_NONE;
                    n_acked = '0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_p_v      <= 1'b0;
            r_pend_v   <= 1'b0;
            r_send_seq <= '0;
            r_rx       <= '0;
            r_ack_owed <= 1'b0;
            r_used     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_p_v      <= n_p_v;
            r_pend_v   <= n_pend_v;
            r_send_seq <= n_send_seq;
            r_rx       <= n_rx;
            r_ack_owed <= n_ack_owed;
            r_used     <= n_used;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack      <= n_ack;
        r_bits     <= n_bits;
        r_p_seq    <= n_p_seq;
        r_p_slot   <= n_p_slot;
        r_pend_seq <= n_pend_seq;
        r_kind     <= n_kind;
        r_tx_seq   <= n_tx_seq;
        r_tx_ack   <= n_tx_ack;
        r_tx_bits  <= n_tx_bits;
        r_acked    <= n_acked;
        r_last     <= n_last;
    end

    assign o_result_valid = r_out_v;
    assign o_result_kind  = r_kind;
    assign o_tx_seq       = r_tx_seq;
    assign o_tx_ack       = r_tx_ack;
    assign o_tx_ack_bits  = r_tx_bits;
    assign o_acked_seq    = r_acked;
    assign o_last         = r_last;

    a_scan_ends_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(busy)) |-> (o_result_valid && o_last))
        else $error("scan ended without final transfer");

    a_partial_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> busy)
        else $error("non-final transfer outside scan");

    a_build_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == psawt_pkg::CMD_BUILD))
        |=> (o_result_valid && o_last && !busy))
        else $error("build command did not give one final transfer");

endmodule

[sv/psawt_hist_ram.sv]
// ----------------------------------------------------------------------------
// psawt_hist_ram
// Sent-history sequence store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psawt_hist_ram (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  psawt_pkg::t_slot   i_wr_addr,
    input  psawt_pkg::t_seq    i_wr_data,
    input  logic               i_rd_en,
    input  psawt_pkg::t_slot   i_rd_addr,
    output psawt_pkg::t_seq    o_rd_data
);

    psawt_pkg::t_seq r_mem [psawt_pkg::HISTORY_DEPTH];
    psawt_pkg::t_seq r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/psawt_win_upd.sv]
// ----------------------------------------------------------------------------
// psawt_win_upd
// Receive window update with wrap-safe 16-bit serial comparison.
// ----------------------------------------------------------------------------
module psawt_win_upd (
    input  psawt_pkg::t_rx_state i_cur,
    input  psawt_pkg::t_seq      i_rx_seq,
    output psawt_pkg::t_rx_state o_nxt
);

    psawt_pkg::t_seq ahead;
    psawt_pkg::t_seq back;
    logic            newer;

    always_comb begin
        ahead = i_rx_seq - i_cur.latest;
        back  = i_cur.latest - i_rx_seq;
        newer = (ahead != '0) && !ahead[psawt_pkg::SEQ_W-1];
        o_nxt = i_cur;
        o_nxt.have_received = 1'b1;
        if (!i_cur.have_received) begin
            o_nxt.latest = i_rx_seq;
            o_nxt.window = psawt_pkg::t_win'(1);
        end else if (newer) begin
            if (ahead >= psawt_pkg::SEQ_W'(psawt_pkg::WIN_BITS)) begin
                o_nxt.window = psawt_pkg::t_win'(1);
            end else begin
                o_nxt.window = (i_cur.window << ahead[psawt_pkg::WIN_AW-1:0])
                             | psawt_pkg::t_win'(1);
            end
            o_nxt.latest = i_rx_seq;
        end else if (back < psawt_pkg::SEQ_W'(psawt_pkg::WIN_BITS)) begin
            o_nxt.window = i_cur.window
                         | (psawt_pkg::t_win'(1) << back[psawt_pkg::WIN_AW-1:0]);
        end
    end

endmodule
